### rtl/uer_pkg.sv
package uer_pkg;

    localparam int TICK_BITS = 16;

    localparam int TIMEOUT_W = 8;
    localparam int TRIGGER_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int WAIT_W = 9;
    localparam int WIDTH_W = 9;
    localparam int DIST_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_CYCLES = 1'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd40;
    localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = 16'd1000;

    typedef struct packed {
        logic start_req;
        logic tick;
        logic echo;
    } uer_in_t;

    typedef struct packed {
        logic               trigger_level;
        logic               busy_res;
        logic               done_res;
        logic               timed_out;
        logic [WIDTH_W-1:0] width_ticks;
        logic [DIST_W-1:0]  distance_cm;
    } uer_out_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [TRIGGER_W-1:0] trigger_cycles;
    } uer_cfg_t;

    // (343*w + 10) / 20 = 17*w + (3*w + 10) / 20; the small quotient uses 205/4096
    function automatic logic [DIST_W-1:0] dist_of(input logic [WIDTH_W-1:0] w);
        logic [9:0]        z;
        logic [17:0]       p;
        logic [DIST_W-1:0] base;
        z = 10'({1'b0, w} + {w, 1'b0}) + 10'd10;
        p = 18'(z) * 18'd205;
        base = {w, 4'd0} + DIST_W'(w);
        return base + DIST_W'(p[17:12]);
    endfunction

endpackage

### rtl/uer_ctrl.sv
module uer_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  uer_pkg::uer_in_t  item,
    input  uer_pkg::uer_cfg_t cfg,
    output uer_pkg::uer_out_t res
);
    import uer_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_FALL = 2'd3;

    logic [1:0]           phase_reg, phase_next;
    logic [TRIGGER_W-1:0] trig_cnt_reg, trig_cnt_next;
    logic [TICK_BITS-1:0] tick_cnt_reg, tick_cnt_next;
    logic [TICK_BITS-1:0] start_tick_reg, start_tick_next;
    logic [WAIT_W-1:0]    wait_cnt_reg, wait_cnt_next;
    logic [WIDTH_W-1:0]   last_width_reg, last_width_next;
    logic                 echo_prev_reg;

    logic                 rise;
    logic                 fall;
    logic [TICK_BITS-1:0] diff;
    logic                 trig;
    logic                 done;
    logic                 tmo;

    assign rise = item.echo && !echo_prev_reg;
    assign fall = !item.echo && echo_prev_reg;
    assign tick_cnt_next = item.tick ? tick_cnt_reg + 1'b1 : tick_cnt_reg;
    assign diff = tick_cnt_next - start_tick_reg;

    always_comb
    begin
        phase_next = phase_reg;
        trig_cnt_next = trig_cnt_reg;
        start_tick_next = start_tick_reg;
        wait_cnt_next = wait_cnt_reg;
        last_width_next = last_width_reg;
        trig = 1'b0;
        done = 1'b0;
        tmo = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    phase_next = PH_TRIG;
                    trig_cnt_next = TRIGGER_W'(1);
                    wait_cnt_next = '0;
                    trig = 1'b1;
                end
            end
            PH_TRIG:
            begin
                if (trig_cnt_reg >= cfg.trigger_cycles)
                begin
                    phase_next = PH_RISE;
                    wait_cnt_next = '0;
                end
                else
                begin
                    trig_cnt_next = trig_cnt_reg + 1'b1;
                    trig = 1'b1;
                end
            end
            default:
            begin
                if (item.tick && wait_cnt_reg != '1)
                    wait_cnt_next = wait_cnt_reg + 1'b1;
                priority if (phase_reg == PH_FALL && fall)
                begin
                    last_width_next = (diff > TICK_BITS'(256)) ? WIDTH_W'(256)
                                                               : WIDTH_W'(diff);
                    done = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (wait_cnt_next > WAIT_W'(cfg.timeout_ticks))
                begin
                    last_width_next = '0;
                    tmo = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (phase_reg == PH_RISE && rise)
                begin
                    start_tick_next = tick_cnt_next;
                    phase_next = PH_FALL;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            trig_cnt_reg <= '0;
            tick_cnt_reg <= '0;
            start_tick_reg <= '0;
            wait_cnt_reg <= '0;
            last_width_reg <= '0;
            echo_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            trig_cnt_reg <= trig_cnt_next;
            tick_cnt_reg <= tick_cnt_next;
            start_tick_reg <= start_tick_next;
            wait_cnt_reg <= wait_cnt_next;
            last_width_reg <= last_width_next;
            echo_prev_reg <= item.echo;
        end
    end

    always_comb
    begin
        res.trigger_level = trig;
        res.busy_res = (phase_next != PH_IDLE);
        res.done_res = done;
        res.timed_out = tmo;
        res.width_ticks = last_width_next;
        res.distance_cm = dist_of(last_width_next);
    end

    a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && trig |=> phase_reg == PH_TRIG)
        else $error("trigger without trigger phase");

    a_fall_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_RISE && rise && !tmo |=> phase_reg == PH_FALL)
        else $error("rising edge not captured");

    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (done || tmo) |=> phase_reg == PH_IDLE)
        else $error("measurement end did not return to idle");

endmodule

### rtl/ultrasonic_echo_ranger.sv
// A result appears in the output register the cycle after its transaction is accepted.
// One transaction per cycle unless stalled; next state and distance math are combinational.
// A single output register decouples the channels; input stalls only while it is held.
// Reset (rst_n, async, active low): idle, counters cleared, timeout 40, trigger_cycles 1000.
module ultrasonic_echo_ranger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  uer_pkg::uer_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output uer_pkg::uer_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import uer_pkg::*;

    uer_cfg_t cfg_reg;
    uer_out_t res;
    uer_out_t out_data_reg;
    logic     out_valid_reg;
    logic     accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.trigger_cycles <= TRIGGER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
                REG_TRIGGER_CYCLES: cfg_reg.trigger_cycles <= cfg_data[TRIGGER_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    uer_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= accept || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= res;
    end

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted transaction produced no result");

    a_end_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.done_res && out_data.timed_out))
        else $error("done and timeout together");

    a_end_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.done_res || out_data.timed_out) |-> !out_data.busy_res)
        else $error("busy after measurement end");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.trigger_level |-> out_data.busy_res)
        else $error("trigger while not busy");

endmodule
